>>> hdl/tkst_pkg.sv
// Shared types and constants of the top-K sorted score table.
// Used by tkst_ctrl, tkst_dp and top_k_sorted_score_table; depends on nothing.
package tkst_pkg;

   localparam int SCORE_W = 32;
   localparam int TAG_W   = 16;
   localparam int RANK_W  = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_READ   = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      RD_LAST  = 3'd0,
      RD_CNTM1 = 3'd1,
      RD_PREV  = 3'd2,
      RD_PREV2 = 3'd3,
      RD_RANK  = 3'd4
   } rd_sel_type;

   typedef enum logic {
      WR_MOVE = 1'b0,
      WR_NEW  = 1'b1
   } wr_sel_type;

   typedef enum logic [1:0] {
      RSP_PLAIN  = 2'd0,
      RSP_PLACED = 2'd1,
      RSP_READ   = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         idx_load;
      logic         idx_dec;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         cnt_inc;
      logic         cnt_clr;
      logic         rsp_en;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic idx_zero;
      logic idx_one;
      logic rd_less;
   } status_type;

endpackage

>>> hdl/tkst_ctrl.sv
// Controller state machine of the top-K sorted score table.
// Depends on tkst_pkg; drives the command struct of tkst_dp from its status struct.
module tkst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_mode,
   input  tkst_pkg::status_type  status,
   output tkst_pkg::cmd_type     cmd,
   output logic                  busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LAST,
      ST_WALK,
      ST_PUT,
      ST_READ_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (tkst_pkg::mode_type'(req_mode))
                  tkst_pkg::MODE_INSERT: begin
                     cmd.idx_load = 1'b1;
                     if (status.full) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = tkst_pkg::RD_LAST;
                        state_in   = ST_CHK_LAST;
                     end else if (status.empty) begin
                        state_in = ST_PUT;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = tkst_pkg::RD_CNTM1;
                        state_in   = ST_WALK;
                     end
                  end
                  tkst_pkg::MODE_READ: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = tkst_pkg::RD_RANK;
                     state_in   = ST_READ_OUT;
                  end
                  tkst_pkg::MODE_CLEAR: begin
                     cmd.cnt_clr  = 1'b1;
                     cmd.rsp_en   = 1'b1;
                     cmd.rsp_kind = tkst_pkg::RSP_PLAIN;
                  end
                  default: begin
                     cmd.rsp_en   = 1'b1;
                     cmd.rsp_kind = tkst_pkg::RSP_PLAIN;
                  end
               endcase
            end
         end
         ST_CHK_LAST: begin
            if (status.rd_less) begin
               if (status.idx_zero) begin
                  state_in = ST_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = tkst_pkg::RD_PREV;
                  state_in   = ST_WALK;
               end
            end else begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = tkst_pkg::RSP_PLAIN;
               state_in     = ST_IDLE;
            end
         end
         ST_WALK: begin
            cmd.wr_en = 1'b1;
            if (status.rd_less) begin
               cmd.wr_sel  = tkst_pkg::WR_MOVE;
               cmd.idx_dec = 1'b1;
               if (status.idx_one) begin
                  state_in = ST_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = tkst_pkg::RD_PREV2;
               end
            end else begin
               cmd.wr_sel   = tkst_pkg::WR_NEW;
               cmd.cnt_inc  = 1'b1;
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = tkst_pkg::RSP_PLACED;
               state_in     = ST_IDLE;
            end
         end
         ST_PUT: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = tkst_pkg::WR_NEW;
            cmd.cnt_inc  = 1'b1;
            cmd.rsp_en   = 1'b1;
            cmd.rsp_kind = tkst_pkg::RSP_PLACED;
            state_in     = ST_IDLE;
         end
         ST_READ_OUT: begin
            cmd.rsp_en   = 1'b1;
            cmd.rsp_kind = tkst_pkg::RSP_READ;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

>>> hdl/tkst_dp.sv
// Datapath of the top-K sorted score table: entry memory, walk pointer, count, result registers.
// Depends on tkst_pkg; obeys the command struct from tkst_ctrl.
module tkst_dp #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [tkst_pkg::SCORE_W-1:0] req_entry_score,
   input  logic [tkst_pkg::TAG_W-1:0]          req_entry_tag,
   input  logic [tkst_pkg::RANK_W-1:0]         req_read_rank,
   input  tkst_pkg::cmd_type                   cmd,
   output tkst_pkg::status_type                status,
   output logic                                rsp_strobe,
   output logic                                rsp_placed,
   output logic [tkst_pkg::RANK_W-1:0]         rsp_placed_rank,
   output logic                                rsp_read_valid,
   output logic signed [tkst_pkg::SCORE_W-1:0] rsp_out_score,
   output logic [tkst_pkg::TAG_W-1:0]          rsp_out_tag,
   output logic [tkst_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = tkst_pkg::SCORE_W + tkst_pkg::TAG_W;
   localparam int SW = tkst_pkg::SCORE_W;
   localparam int TW = tkst_pkg::TAG_W;
   localparam int RW = tkst_pkg::RANK_W;
   localparam int NW = tkst_pkg::COUNT_W;

   // Entry memory, score in the upper bits and tag in the lower bits.
   logic [EW-1:0]        store_ff [TABLE_DEPTH];
   logic [EW-1:0]        rdata_ff;

   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [AW-1:0]        idx_ff;
   logic signed [SW-1:0] new_score_ff;
   logic [TW-1:0]        new_tag_ff;
   logic [RW-1:0]        rank_ff;

   logic                 rsp_strobe_ff;
   logic                 placed_ff;
   logic [RW-1:0]        placed_rank_ff;
   logic                 read_valid_ff;
   logic signed [SW-1:0] out_score_ff;
   logic [TW-1:0]        out_tag_ff;
   logic [NW-1:0]        entry_count_ff;

   logic                 full;
   logic                 rank_ok;
   logic [AW-1:0]        rd_addr;
   logic [EW-1:0]        wr_data;
   logic [CW-1:0]        cnt_m1;
   logic [AW+RW-1:0]     req_rank_wide;
   logic [AW+RW-1:0]     idx_rank_wide;
   logic [CW+NW-1:0]     count_wide;
   logic signed [SW-1:0] rd_score;

   assign full          = (count_ff == CW'(TABLE_DEPTH));
   assign cnt_m1        = count_ff - CW'(1);
   assign req_rank_wide = {{AW{1'b0}}, req_read_rank};
   assign idx_rank_wide = {{RW{1'b0}}, idx_ff};
   assign count_wide    = {{NW{1'b0}}, count_in};
   assign rank_ok       = ({{CW{1'b0}}, rank_ff} < {{RW{1'b0}}, count_ff});
   assign rd_score      = $signed(rdata_ff[EW-1:TW]);

   assign status.full     = full;
   assign status.empty    = (count_ff == '0);
   assign status.idx_zero = (idx_ff == '0);
   assign status.idx_one  = (idx_ff == AW'(1));
   assign status.rd_less  = (rd_score < new_score_ff);

   always_comb begin
      case (cmd.rd_sel)
         tkst_pkg::RD_LAST:  rd_addr = AW'(TABLE_DEPTH - 1);
         tkst_pkg::RD_CNTM1: rd_addr = cnt_m1[AW-1:0];
         tkst_pkg::RD_PREV:  rd_addr = idx_ff - AW'(1);
         tkst_pkg::RD_PREV2: rd_addr = idx_ff - AW'(2);
         tkst_pkg::RD_RANK:  rd_addr = req_rank_wide[AW-1:0];
         default:            rd_addr = '0;
      endcase
   end

   assign wr_data = (cmd.wr_sel == tkst_pkg::WR_NEW) ? {new_score_ff, new_tag_ff} : rdata_ff;

   always_comb begin
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc && !full) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[idx_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_score_ff <= req_entry_score;
         new_tag_ff   <= req_entry_tag;
         rank_ff      <= req_read_rank;
      end
      if (cmd.idx_load) begin
         idx_ff <= full ? AW'(TABLE_DEPTH - 1) : count_ff[AW-1:0];
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_en) begin
         entry_count_ff <= count_wide[NW-1:0];
         case (cmd.rsp_kind)
            tkst_pkg::RSP_PLACED: begin
               placed_ff      <= 1'b1;
               placed_rank_ff <= idx_rank_wide[RW-1:0];
               read_valid_ff  <= 1'b0;
               out_score_ff   <= '0;
               out_tag_ff     <= '0;
            end
            tkst_pkg::RSP_READ: begin
               placed_ff      <= 1'b0;
               placed_rank_ff <= '0;
               read_valid_ff  <= rank_ok;
               out_score_ff   <= rank_ok ? rd_score : '0;
               out_tag_ff     <= rank_ok ? rdata_ff[TW-1:0] : '0;
            end
            default: begin
               placed_ff      <= 1'b0;
               placed_rank_ff <= '0;
               read_valid_ff  <= 1'b0;
               out_score_ff   <= '0;
               out_tag_ff     <= '0;
            end
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_placed      = placed_ff;
   assign rsp_placed_rank = placed_rank_ff;
   assign rsp_read_valid  = read_valid_ff;
   assign rsp_out_score   = out_score_ff;
   assign rsp_out_tag     = out_tag_ff;
   assign rsp_entry_count = entry_count_ff;

endmodule

>>> hdl/top_k_sorted_score_table.sv
// Top level of the top-K sorted score table.
// Depends on tkst_pkg, tkst_ctrl and tkst_dp.

// The table holds up to TABLE_DEPTH entries of a signed 32-bit score and a 16-bit tag,
// kept in descending score order with equal scores in arrival order. A transaction is
// accepted at a rising edge with start high and busy low, and each transaction gives
// exactly one result, shown for one cycle with rsp_strobe high; the receiver cannot stall
// it, so it must take every result in that cycle. A clear or an unused mode code answers
// in the cycle after acceptance and leaves busy low. A read passes through the ST_READ_OUT
// state before it answers. An insert walks the entry memory from the tail toward the head,
// moving one entry down per cycle through its single write port while the next entry is
// read; when the table is already full, the tail entry is checked first. Busy falls in the
// cycle the result appears, so the next transaction may be accepted there. The entry
// memory needs no clearing after reset: only ranks below the entry count are reported.
module top_k_sorted_score_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_mode,
   input  logic signed [tkst_pkg::SCORE_W-1:0] req_entry_score,
   input  logic [tkst_pkg::TAG_W-1:0]          req_entry_tag,
   input  logic [tkst_pkg::RANK_W-1:0]         req_read_rank,
   output logic                                rsp_strobe,
   output logic                                rsp_placed,
   output logic [tkst_pkg::RANK_W-1:0]         rsp_placed_rank,
   output logic                                rsp_read_valid,
   output logic signed [tkst_pkg::SCORE_W-1:0] rsp_out_score,
   output logic [tkst_pkg::TAG_W-1:0]          rsp_out_tag,
   output logic [tkst_pkg::COUNT_W-1:0]        rsp_entry_count
);

   tkst_pkg::cmd_type    cmd;
   tkst_pkg::status_type status;
   logic                 start_ok;

   // The controller only sees start while it is idle, which is exactly when busy is low.
   assign start_ok = start && !busy;

   tkst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ok),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   tkst_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_entry_score (req_entry_score),
      .req_entry_tag   (req_entry_tag),
      .req_read_rank   (req_read_rank),
      .cmd             (cmd),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_placed      (rsp_placed),
      .rsp_placed_rank (rsp_placed_rank),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_out_score   (rsp_out_score),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_entry_count (rsp_entry_count)
   );

   // An accepted insert or read keeps the block busy in the following cycle.
   a_busy_after_walk: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == tkst_pkg::MODE_INSERT || req_mode == tkst_pkg::MODE_READ)
      |=> busy)
      else $error("insert or read accepted but block not busy");

   // A clear answers in the next cycle with an empty table.
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == tkst_pkg::MODE_CLEAR
      |=> rsp_strobe && rsp_entry_count == '0)
      else $error("clear did not answer with an empty table");

   // A result never reports both a placed insert and a valid read.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_placed |-> !rsp_read_valid)
      else $error("result marks both placed and read_valid");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the top-K sorted score table.
// Depends on tkst_pkg and top_k_sorted_score_table; a built-in predictor checks every result.
module testbench;

   localparam int SCORE_W = tkst_pkg::SCORE_W;
   localparam int TAG_W   = tkst_pkg::TAG_W;
   localparam int RANK_W  = tkst_pkg::RANK_W;
   localparam int COUNT_W = tkst_pkg::COUNT_W;

   // Mode code 3 is unused by the block. It must change nothing and answer
   // with the entry count alone.
   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam int         DEPTH         = 16;
   localparam int         RANDOM_ITEMS  = 1550;
   // After the last result the bench waits a little longer than the slowest
   // insert so that a stray late strobe is still seen.
   localparam int         SETTLE_CYCLES = 24;

   // One command as the driver presents it. wait_drained makes the driver
   // hold the command back until every earlier transaction has answered.
   typedef struct {
      logic [1:0]             mode;
      logic [SCORE_W-1:0]     score;
      logic [TAG_W-1:0]       tag;
      logic [RANK_W-1:0]      rank;
      bit                     wait_drained;
   } board_cmd_type;

   typedef struct packed {
      logic                   placed;
      logic [RANK_W-1:0]      placed_rank;
      logic                   read_valid;
      logic [SCORE_W-1:0]     out_score;
      logic [TAG_W-1:0]       out_tag;
      logic [COUNT_W-1:0]     entry_count;
   } board_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_mode = tkst_pkg::MODE_CLEAR;
   logic signed [SCORE_W-1:0] req_entry_score = '0;
   logic [TAG_W-1:0]          req_entry_tag = '0;
   logic [RANK_W-1:0]         req_read_rank = '0;
   logic                      rsp_strobe;
   logic                      rsp_placed;
   logic [RANK_W-1:0]         rsp_placed_rank;
   logic                      rsp_read_valid;
   logic signed [SCORE_W-1:0] rsp_out_score;
   logic [TAG_W-1:0]          rsp_out_tag;
   logic [COUNT_W-1:0]        rsp_entry_count;

   top_k_sorted_score_table #(
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_entry_score(req_entry_score),
      .req_entry_tag(req_entry_tag),
      .req_read_rank(req_read_rank),
      .rsp_strobe(rsp_strobe),
      .rsp_placed(rsp_placed),
      .rsp_placed_rank(rsp_placed_rank),
      .rsp_read_valid(rsp_read_valid),
      .rsp_out_score(rsp_out_score),
      .rsp_out_tag(rsp_out_tag),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Commands that still wait to be presented, and the results that accepted
   // transactions are owed, oldest first.
   board_cmd_type    cmd_backlog[$];
   board_result_type awaited_results[$];

   // The predictor's own copy of the table. Only ranks below board_fill are
   // meaningful, just as in the block.
   logic signed [SCORE_W-1:0] board_score [DEPTH];
   logic [TAG_W-1:0]          board_tag [DEPTH];
   int                        board_fill = 0;

   int  failure_count  = 0;
   int  answered_count = 0;
   int  gap_left       = 0;
   bit  idle_on        = 1'b1;

   // Applies one accepted command to the predicted table and returns the
   // result the block must give for it.
   function automatic board_result_type apply_to_board(board_cmd_type cmd);
      board_result_type r;
      int               pos;
      int               last;
      int               i;
      r = '0;
      case (cmd.mode)
         tkst_pkg::MODE_INSERT: begin
            // Equal scores stay in arrival order, so the new entry goes
            // after every entry that is greater or equal.
            pos = 0;
            while (pos < board_fill && board_score[pos] >= $signed(cmd.score))
               pos++;
            // When the table is full and the new score is the lowest, pos
            // runs off the end and the entry is simply dropped.
            if (pos < DEPTH) begin
               last = (board_fill < DEPTH) ? board_fill : DEPTH - 1;
               for (i = last; i > pos; i--) begin
                  board_score[i] = board_score[i - 1];
                  board_tag[i]   = board_tag[i - 1];
               end
               board_score[pos] = cmd.score;
               board_tag[pos]   = cmd.tag;
               if (board_fill < DEPTH)
                  board_fill++;
               r.placed      = 1'b1;
               r.placed_rank = RANK_W'(pos);
            end
         end
         tkst_pkg::MODE_READ: begin
            if (int'(cmd.rank) < board_fill) begin
               r.read_valid = 1'b1;
               r.out_score  = board_score[cmd.rank];
               r.out_tag    = board_tag[cmd.rank];
            end
         end
         tkst_pkg::MODE_CLEAR: begin
            board_fill = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = COUNT_W'(board_fill);
      return r;
   endfunction

   task automatic queue_cmd(logic [1:0] mode, logic [SCORE_W-1:0] score,
                            logic [TAG_W-1:0] tag, logic [RANK_W-1:0] rank,
                            bit wait_drained);
      board_cmd_type c;
      c.mode         = mode;
      c.score        = score;
      c.tag          = tag;
      c.rank         = rank;
      c.wait_drained = wait_drained;
      cmd_backlog.insert(cmd_backlog.size(), c);
   endtask

   // Scores lean toward the extremes and toward a narrow band around zero,
   // so that ties and full-table drops come up often.
   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000 + 32'($urandom_range(0, 1));
         1:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 1));
         2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   task automatic note_failure(string msg);
      failure_count++;
      if (failure_count <= 10)
         $display("%s", msg);
   endtask

   // Driver. A transaction is accepted at an edge where start is high and
   // busy is low; the prediction is made right there. A new command is put
   // up only when no command is on offer or the current one was just
   // accepted, so start is assigned once per edge at most.
   always @(posedge clock) begin
      board_cmd_type next_cmd;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            next_cmd.mode  = req_mode;
            next_cmd.score = req_entry_score;
            next_cmd.tag   = req_entry_tag;
            next_cmd.rank  = req_read_rank;
            awaited_results.insert(awaited_results.size(), apply_to_board(next_cmd));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (cmd_backlog.size() != 0 &&
                         (!cmd_backlog[0].wait_drained ||
                          (!rsp_strobe && awaited_results.size() == 0))) begin
               // A strobe seen at this edge means the monitor is still
               // taking a result, so a drained command is not put up at this edge.
               next_cmd        = cmd_backlog.pop_front();
               req_mode        <= next_cmd.mode;
               req_entry_score <= next_cmd.score;
               req_entry_tag   <= next_cmd.tag;
               req_read_rank   <= next_cmd.rank;
               start           <= 1'b1;
               // Idle bursts come and go in stretches, and stop altogether
               // for the last part of the run.
               if ($urandom_range(0, 39) == 0)
                  idle_on = !idle_on;
               if (idle_on && cmd_backlog.size() > 200 && $urandom_range(0, 2) == 0)
                  gap_left = $urandom_range(1, 13);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. A result is valid for exactly the cycle that rsp_strobe is
   // high and is taken at the edge that ends it; it is matched with the
   // oldest outstanding transaction.
   always @(posedge clock) begin
      board_result_type got;
      board_result_type want;
      if (!reset && rsp_strobe) begin
         got.placed      = rsp_placed;
         got.placed_rank = rsp_placed_rank;
         got.read_valid  = rsp_read_valid;
         got.out_score   = rsp_out_score;
         got.out_tag     = rsp_out_tag;
         got.entry_count = rsp_entry_count;
         if (awaited_results.size() == 0) begin
            note_failure($sformatf({"result with no transaction outstanding: ",
               "placed=%0b rank=%0d valid=%0b score=%h tag=%h count=%0d"},
               got.placed, got.placed_rank, got.read_valid, got.out_score,
               got.out_tag, got.entry_count));
         end else begin
            want = awaited_results.pop_front();
            if (got !== want)
               note_failure($sformatf({"transaction %0d mismatch:\n",
                  "  expected placed=%0b rank=%0d valid=%0b score=%h tag=%h count=%0d\n",
                  "  actual   placed=%0b rank=%0d valid=%0b score=%h tag=%h count=%0d"},
                  answered_count, want.placed, want.placed_rank, want.read_valid,
                  want.out_score, want.out_tag, want.entry_count,
                  got.placed, got.placed_rank, got.read_valid, got.out_score,
                  got.out_tag, got.entry_count));
         end
         answered_count++;
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      int n;
      int k;
      int pick;
      int clear_pct;
      logic [1:0] mode;

      // Directed part: empty-table read, extreme scores and tags, a tie at
      // the top, reads inside and beyond the count, the unused mode code,
      // then a full table where the lowest score is dropped and a new top
      // score pushes the tail entry out.
      queue_cmd(tkst_pkg::MODE_CLEAR, '0, '0, '0, 1'b0);
      queue_cmd(tkst_pkg::MODE_READ, '0, '0, 4'd0, 1'b0);
      queue_cmd(tkst_pkg::MODE_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 4'hF, 1'b0);
      queue_cmd(tkst_pkg::MODE_INSERT, 32'h8000_0000, 16'h0000, 4'h0, 1'b0);
      queue_cmd(tkst_pkg::MODE_INSERT, 32'h7FFF_FFFF, 16'h0001, 4'h0, 1'b0);
      queue_cmd(tkst_pkg::MODE_READ, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 1'b0);
      queue_cmd(tkst_pkg::MODE_READ, '0, '0, 4'd1, 1'b0);
      queue_cmd(tkst_pkg::MODE_READ, '0, '0, 4'd15, 1'b0);
      queue_cmd(MODE_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b0);
      for (n = 0; n < 13; n++)
         queue_cmd(tkst_pkg::MODE_INSERT, pick_score(), 16'($urandom), 4'($urandom), 1'b0);
      queue_cmd(tkst_pkg::MODE_INSERT, 32'h8000_0000, 16'hA5A5, 4'h0, 1'b0);
      queue_cmd(tkst_pkg::MODE_INSERT, 32'h7FFF_FFFF, 16'h5A5A, 4'h0, 1'b0);
      queue_cmd(tkst_pkg::MODE_READ, '0, '0, 4'd15, 1'b0);
      queue_cmd(tkst_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b0);
      queue_cmd(tkst_pkg::MODE_READ, '0, '0, 4'd0, 1'b0);

      // Random part. Inserts dominate so the table fills and stays full for
      // long stretches; the clear rate changes every hundred commands so
      // that both nearly empty and long-full tables are covered.
      clear_pct = 2;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            clear_pct = $urandom_range(0, 6);
         pick = $urandom_range(0, 99);
         if (pick < clear_pct)
            mode = tkst_pkg::MODE_CLEAR;
         else if (pick < clear_pct + 3)
            mode = MODE_RESERVED;
         else if (pick < 60)
            mode = tkst_pkg::MODE_INSERT;
         else
            mode = tkst_pkg::MODE_READ;
         // The first random command, and a few more later, wait until the
         // block has answered everything before them.
         queue_cmd(mode, pick_score(), 16'($urandom), 4'($urandom_range(0, 15)),
                   n == 0 || $urandom_range(0, 99) == 0);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || start)
         @(posedge clock);
      for (k = 0; k < 200 && awaited_results.size() != 0; k++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failure_count == 0 && awaited_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, which is every insert
   // taking its longest walk plus the longest idle burst.
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
hdl/tkst_pkg.sv
hdl/tkst_ctrl.sv
hdl/tkst_dp.sv
hdl/top_k_sorted_score_table.sv
bench/testbench.sv
